### hdl/gru_recurrent_cell_defines.svh
// assertion macros for the gru recurrent cell
`ifndef GRU_RECURRENT_CELL_DEFINES_SVH
`define GRU_RECURRENT_CELL_DEFINES_SVH

// same-cycle implication, checked out of reset
`define GRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define GRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### hdl/grc_pkg.sv
// types, constants and activation functions of the gru recurrent cell
package grc_pkg;

  localparam int IN_N   = 4;
  localparam int HID_N  = 8;
  localparam int DW     = 16;
  localparam int FRAC   = 12;
  localparam int CAT_N  = IN_N + HID_N;
  localparam int GATE_N = 2 * HID_N;
  localparam int GB_BASE  = CAT_N * GATE_N;
  localparam int CW_BASE  = GB_BASE + GATE_N;
  localparam int CB_BASE  = CW_BASE + CAT_N * HID_N;
  localparam int ADDR_N   = CB_BASE + HID_N;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  localparam logic signed [DW-1:0] ONE = 16'sd4096;

  typedef struct packed {
    logic              cmd;
    logic [8:0]        weight_addr;
    logic signed [15:0] weight_value;
    logic signed [15:0] in_0;
    logic signed [15:0] in_1;
    logic signed [15:0] in_2;
    logic signed [15:0] in_3;
    logic              seq_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] h_0;
    logic signed [15:0] h_1;
    logic signed [15:0] h_2;
    logic signed [15:0] h_3;
    logic signed [15:0] h_4;
    logic signed [15:0] h_5;
    logic signed [15:0] h_6;
    logic signed [15:0] h_7;
  } out_item_t;

  // one multiply-accumulate operation
  typedef struct packed {
    logic       vld;
    logic       bias;
    logic [3:0] idx;
    logic       cand;
    logic       last;
    logic [3:0] col;
    logic [8:0] addr;
  } dp_op_t;

  typedef struct packed {
    logic   wr;
    logic   start;
    logic   commit;
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic out_busy;
  } dp_stat_t;

  function automatic logic signed [DW-1:0] rnd_sat(input logic signed [36:0] x);
    logic signed [36:0] t;
    t = (x + 37'sd2048) >>> FRAC;
    if (t > 37'sd32767) return 16'sh7fff;
    if (t < -37'sd32768) return 16'sh8000;
    return t[DW-1:0];
  endfunction

  function automatic logic [12:0] plan(input logic [17:0] a);
    logic [17:0] r;
    if (a >= 18'd20480) r = 18'd4096;
    else if (a >= 18'd9728) r = (a >> 5) + 18'd3456;
    else if (a >= 18'd4096) r = (a >> 3) + 18'd2560;
    else r = (a >> 2) + 18'd2048;
    return r[12:0];
  endfunction

  function automatic logic [16:0] mag(input logic signed [DW-1:0] z);
    logic signed [16:0] e;
    e = {z[DW-1], z};
    return z[DW-1] ? 17'(-e) : 17'(e);
  endfunction

  function automatic logic signed [DW-1:0] sigm(input logic signed [DW-1:0] z);
    logic [12:0] p;
    p = plan({1'b0, mag(z)});
    return z[DW-1] ? ONE - $signed({3'b000, p}) : $signed({3'b000, p});
  endfunction

  function automatic logic signed [DW-1:0] tanh_pl(input logic signed [DW-1:0] z);
    logic [12:0] p;
    logic signed [DW-1:0] t;
    p = plan({mag(z), 1'b0});
    t = $signed({2'b00, p, 1'b0}) - ONE;
    return z[DW-1] ? -t : t;
  endfunction

endpackage

### hdl/grc_ctrl.sv
// sequencer that walks the weight words of one step
module grc_ctrl import grc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_cmd,
  output logic     in_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_DRAIN, S_COMMIT} state_t;

  state_t     state_r;
  logic       phase_r;
  logic [3:0] col_r;
  logic [3:0] row_r;
  dp_op_t     op_r;
  logic [3:0] last_col;
  logic [3:0] ridx;
  logic [8:0] addr;
  logic       acc;

  assign in_ready = (state_r == S_IDLE);
  assign acc      = in_valid && in_ready;
  assign last_col = phase_r ? 4'(HID_N - 1) : 4'(GATE_N - 1);
  assign ridx     = row_r - 4'd1;

  always_comb begin
    if (!phase_r) begin
      addr = (row_r == 4'd0) ? 9'(GB_BASE) + {5'd0, col_r}
                             : {1'b0, ridx, 4'd0} + {5'd0, col_r};
    end else begin
      addr = (row_r == 4'd0) ? 9'(CB_BASE) + {5'd0, col_r}
                             : 9'(CW_BASE) + {2'b0, ridx, 3'd0} + {5'd0, col_r};
    end
  end

  assign cmd.wr     = acc && (in_cmd == CMD_LOAD);
  assign cmd.start  = acc && (in_cmd == CMD_STEP);
  assign cmd.commit = (state_r == S_COMMIT) && !stat.out_busy;
  assign cmd.op     = op_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      phase_r <= 1'b0;
      col_r   <= 4'd0;
      row_r   <= 4'd0;
      op_r    <= '0;
    end else begin
      op_r.vld <= (state_r == S_RUN);
      unique case (state_r)
        S_IDLE: begin
          if (cmd.start) begin
            state_r <= S_RUN;
            phase_r <= 1'b0;
            col_r   <= 4'd0;
            row_r   <= 4'd0;
          end
        end
        S_RUN: begin
          op_r.bias <= (row_r == 4'd0);
          op_r.idx  <= ridx;
          op_r.cand <= phase_r;
          op_r.last <= (row_r == 4'(CAT_N));
          op_r.col  <= col_r;
          op_r.addr <= addr;
          if (row_r == 4'(CAT_N)) begin
            row_r <= 4'd0;
            if (col_r == last_col) begin
              col_r <= 4'd0;
              if (phase_r) state_r <= S_DRAIN;
              else phase_r <= 1'b1;
            end else begin
              col_r <= col_r + 4'd1;
            end
          end else begin
            row_r <= row_r + 4'd1;
          end
        end
        S_DRAIN: begin
          if (stat.done) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          if (!stat.out_busy) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

### hdl/grc_datapath.sv
// weight memory, shared multiply-accumulate and activation pipeline
module grc_datapath import grc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  dp_cmd_t   cmd,
  input  logic      out_ready,
  output logic      out_valid,
  output out_item_t out_data,
  output dp_stat_t  stat
);

  typedef struct packed {
    logic       vld;
    logic       cand;
    logic [3:0] col;
  } post_t;

  logic signed [DW-1:0] mem [ADDR_N];
  logic signed [DW-1:0] mem_q;
  logic signed [DW-1:0] x_r    [IN_N];
  logic signed [DW-1:0] h_r    [HID_N];
  logic signed [DW-1:0] rh_r   [HID_N];
  logic signed [DW-1:0] hnew_r [HID_N];
  logic signed [DW-1:0] gate_r [GATE_N];
  dp_op_t               s1_r, s2_r, s3_r;
  logic signed [31:0]   prod_r;
  logic signed [35:0]   acc_r;
  post_t                p1_r, p2_r, p3_r;
  logic signed [DW-1:0] z_r, act_r;
  logic signed [31:0]   pa_r, pb_r;
  logic                 done_r;
  logic                 out_valid_r;
  out_item_t            out_r;
  logic signed [DW-1:0] opnd;
  logic [2:0]           hidx;
  logic [2:0]           c3;
  logic signed [DW-1:0] u;

  assign hidx = 3'(s1_r.idx - 4'(IN_N));
  assign c3   = p2_r.col[2:0];
  assign u    = gate_r[{1'b1, c3}];

  always_comb begin
    if (s1_r.idx < 4'(IN_N)) opnd = x_r[s1_r.idx[1:0]];
    else if (s1_r.cand) opnd = rh_r[hidx];
    else opnd = h_r[hidx];
  end

  always_ff @(posedge clk) begin
    if (cmd.wr && (in_data.weight_addr < 9'(ADDR_N)))
      mem[in_data.weight_addr] <= in_data.weight_value;
    if (cmd.op.vld) mem_q <= mem[cmd.op.addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
      p1_r <= '0;
      p2_r <= '0;
      p3_r <= '0;
      done_r <= 1'b0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < HID_N; i++) h_r[i] <= '0;
    end else begin
      s1_r <= cmd.op;
      s2_r <= s1_r;
      s3_r <= s2_r;
      done_r <= p3_r.vld && p3_r.cand && (p3_r.col == 4'(HID_N - 1));
      if (cmd.start) begin
        x_r[0] <= in_data.in_0;
        x_r[1] <= in_data.in_1;
        x_r[2] <= in_data.in_2;
        x_r[3] <= in_data.in_3;
        if (in_data.seq_start)
          for (int i = 0; i < HID_N; i++) h_r[i] <= '0;
      end
      // multiply stage
      if (s1_r.vld) begin
        if (s1_r.bias) prod_r <= {{4{mem_q[DW-1]}}, mem_q, 12'd0};
        else prod_r <= opnd * mem_q;
      end
      // accumulate stage
      if (s2_r.vld)
        acc_r <= (s2_r.bias ? 36'sd0 : acc_r) + {{4{prod_r[31]}}, prod_r};
      // round to pre-activation
      p1_r.vld  <= s3_r.vld && s3_r.last;
      p1_r.cand <= s3_r.cand;
      p1_r.col  <= s3_r.col;
      if (s3_r.vld && s3_r.last) z_r <= rnd_sat({acc_r[35], acc_r});
      // activation
      p2_r <= p1_r;
      if (p1_r.vld) begin
        act_r <= p1_r.cand ? tanh_pl(z_r) : sigm(z_r);
        if (!p1_r.cand) gate_r[p1_r.col] <= sigm(z_r);
      end
      // gate products
      p3_r <= p2_r;
      if (p2_r.vld) begin
        if (!p2_r.cand) begin
          pa_r <= act_r * h_r[c3];
        end else begin
          pa_r <= u * h_r[c3];
          pb_r <= (ONE - u) * act_r;
        end
      end
      // write back
      if (p3_r.vld) begin
        if (!p3_r.cand && !p3_r.col[3])
          rh_r[p3_r.col[2:0]] <= rnd_sat({{5{pa_r[31]}}, pa_r});
        if (p3_r.cand)
          hnew_r[p3_r.col[2:0]] <= rnd_sat({{5{pa_r[31]}}, pa_r} + {{5{pb_r[31]}}, pb_r});
      end
      if (cmd.commit) begin
        for (int i = 0; i < HID_N; i++) h_r[i] <= hnew_r[i];
        out_valid_r <= 1'b1;
        out_r <= {hnew_r[0], hnew_r[1], hnew_r[2], hnew_r[3],
                  hnew_r[4], hnew_r[5], hnew_r[6], hnew_r[7]};
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_r;
  assign stat.done     = done_r;
  assign stat.out_busy = out_valid_r && !out_ready;

endmodule

### hdl/gru_recurrent_cell.sv
// top level of the gru recurrent cell
// Usage:
//  in channel (in_valid/in_ready/in_data): cmd load writes one weight word to
//  weight_addr in the cycle it is taken (addresses past the candidate bias are
//  dropped) and gives no result; cmd step runs one time step on in_0..in_3,
//  seq_start zeroes the hidden state first.
//  out channel (out_valid/out_ready/out_data): one item h_0..h_7 per step.
//  Timing: a step item streams every weight word of the step, one word per
//  cycle from the single read port of the weight memory, through the single
//  multiply-accumulate, then drains the pipeline and commits its result.
//  in_ready is low from a step's acceptance until its commit, so no other item
//  is taken while a step runs; loads are taken one per cycle while idle.
//  Reset: hidden state cleared, output empty, weights undefined until loaded.
//  A stalled receiver holds the result in the output register; the next item
//  is still taken, and a step finishing while the old result waits holds
//  until out_ready frees the register.
`include "gru_recurrent_cell_defines.svh"
module gru_recurrent_cell import grc_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  dp_cmd_t  dp_cmd;
  dp_stat_t dp_stat;

  grc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_data.cmd),
    .in_ready (in_ready),
    .stat     (dp_stat),
    .cmd      (dp_cmd)
  );

  grc_datapath u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cmd       (dp_cmd),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (dp_stat)
  );

  `GRC_ASSERT_NEXT(a_busy_after_step, dp_cmd.start, !in_ready, "step did not make engine busy")
  `GRC_ASSERT_NOW(a_done_busy, dp_stat.done, !in_ready, "step done while idle")
  `GRC_ASSERT_NOW(a_commit_free, dp_cmd.commit, !out_valid || out_ready, "result overwritten")

endmodule

### dv/gru_recurrent_cell_tb.sv
// self-checking gru cell testbench: all weights loaded, directed table, random loads and steps
`timescale 1ns / 100ps
module gru_recurrent_cell_tb;
  import grc_pkg::*;

  localparam int N_RAND    = 880;
  localparam int DRAIN_CYC = 400;
  localparam int MAX_CYC   = 1500000;
  localparam int HOLD_CYC  = 3000;

  typedef struct packed {
    logic        cmd;
    logic [8:0]  addr;
    logic [15:0] val;
    logic [15:0] x0;
    logic [15:0] x1;
    logic [15:0] x2;
    logic [15:0] x3;
    logic        start;
    logic        chk;
    logic [15:0] e0;
    logic [15:0] erest;
  } row_t;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  longint    gw_mem [GB_BASE];
  longint    gb_mem [GATE_N];
  longint    cw_mem [CAT_N*HID_N];
  longint    cb_mem [HID_N];
  longint    hid_vec [HID_N];
  out_item_t state_q [$];
  int        errors;
  int        cycles;
  bit        quiet;
  bit        hold_req;

  row_t dir_tbl [12] = '{
    '{CMD_STEP, 9'd0, 16'h0000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b1, 1'b1, 16'd0, 16'd0},
    '{CMD_LOAD, 9'(CB_BASE), 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_STEP, 9'd0, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b1, 16'd2048, 16'd0},
    '{CMD_STEP, 9'd0, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b1, 16'd3072, 16'd0},
    '{CMD_STEP, 9'd0, 16'h0000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b1, 1'b1, 16'd2048, 16'd0},
    '{CMD_LOAD, 9'd312, 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_LOAD, 9'd511, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_LOAD, 9'd0, 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_LOAD, 9'(GB_BASE+8), 16'h7fff, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_LOAD, 9'(CW_BASE+1), 16'h8000, 16'h0, 16'h0, 16'h0, 16'h0, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_STEP, 9'h1ff, 16'hffff, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff, 1'b0, 1'b0, 16'd0, 16'd0},
    '{CMD_STEP, 9'h1ff, 16'hffff, 16'h8000, 16'h7fff, 16'h0001, 16'hffff, 1'b0, 1'b0, 16'd0, 16'd0}
  };

  gru_recurrent_cell i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  function automatic longint round_q12(longint x);
    longint t;
    t = (x + 2048) >>> FRAC;
    if (t > 32767) return 32767;
    if (t < -32768) return -32768;
    return t;
  endfunction

  function automatic longint pwl(longint a);
    if (a >= 20480) return 4096;
    if (a >= 9728) return (a >>> 5) + 3456;
    if (a >= 4096) return (a >>> 3) + 2560;
    return (a >>> 2) + 2048;
  endfunction

  function automatic longint sigmoid_q(longint z);
    longint p;
    p = pwl(z < 0 ? -z : z);
    return z < 0 ? 4096 - p : p;
  endfunction

  function automatic longint tanh_q(longint z);
    longint t;
    t = 2 * pwl(2 * (z < 0 ? -z : z)) - 4096;
    return z < 0 ? -t : t;
  endfunction

  function automatic longint clamp_acc(longint v);
    longint lim;
    lim = longint'(1) << 61;
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  function automatic void apply_item(in_item_t it);
    longint    cat [CAT_N];
    longint    gate [GATE_N];
    longint    hn [HID_N];
    longint    acc;
    longint    c;
    out_item_t o;
    int        a;
    a = int'(it.weight_addr);
    if (it.cmd == CMD_LOAD) begin
      if (a < GB_BASE) gw_mem[a] = longint'(it.weight_value);
      else if (a < CW_BASE) gb_mem[a-GB_BASE] = longint'(it.weight_value);
      else if (a < CB_BASE) cw_mem[a-CW_BASE] = longint'(it.weight_value);
      else if (a < ADDR_N) cb_mem[a-CB_BASE] = longint'(it.weight_value);
      return;
    end
    if (it.seq_start) foreach (hid_vec[k]) hid_vec[k] = 0;
    cat[0] = longint'(it.in_0);
    cat[1] = longint'(it.in_1);
    cat[2] = longint'(it.in_2);
    cat[3] = longint'(it.in_3);
    for (int k = 0; k < HID_N; k++) cat[IN_N+k] = hid_vec[k];
    for (int j = 0; j < GATE_N; j++) begin
      acc = gb_mem[j] * 4096;
      for (int i = 0; i < CAT_N; i++) acc = clamp_acc(acc + cat[i] * gw_mem[i*GATE_N+j]);
      gate[j] = sigmoid_q(round_q12(acc));
    end
    for (int k = 0; k < HID_N; k++) cat[IN_N+k] = round_q12(gate[k] * hid_vec[k]);
    for (int j = 0; j < HID_N; j++) begin
      acc = cb_mem[j] * 4096;
      for (int i = 0; i < CAT_N; i++) acc = clamp_acc(acc + cat[i] * cw_mem[i*HID_N+j]);
      c = tanh_q(round_q12(acc));
      hn[j] = round_q12(gate[HID_N+j] * hid_vec[j] + (4096 - gate[HID_N+j]) * c);
    end
    for (int j = 0; j < HID_N; j++) begin
      hid_vec[j] = hn[j];
      o[127-16*j -: 16] = hn[j][15:0];
    end
    state_q.insert(state_q.size(), o);
  endfunction

  task automatic send_item(in_item_t it);
    in_data  <= it;
    in_valid <= 1'b1;
    do @(posedge clk); while (!in_ready);
    apply_item(it);
    if (!quiet && $urandom_range(0, 99) < 12) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  function automatic logic [15:0] rand_word(bit wide);
    if (wide) return 16'($urandom);
    return 16'($urandom_range(0, 2047) - 1024);
  endfunction

  function automatic in_item_t rand_item();
    in_item_t it;
    bit       wide;
    wide            = ($urandom_range(0, 99) < 25);
    it.cmd          = ($urandom_range(0, 99) < 40) ? CMD_STEP : CMD_LOAD;
    it.weight_addr  = ($urandom_range(0, 99) < 8) ? 9'($urandom) : 9'($urandom_range(0, ADDR_N-1));
    it.weight_value = rand_word(wide);
    it.in_0         = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    it.in_1         = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    it.in_2         = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    it.in_3         = wide ? 16'($urandom) : 16'($urandom_range(0, 16383) - 8192);
    it.seq_start    = ($urandom_range(0, 99) < 10);
    return it;
  endfunction

  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_req && !hold_done) begin
        out_ready <= 1'b0;
        repeat (HOLD_CYC) @(posedge clk);
        hold_done = 1'b1;
      end
      out_ready <= quiet || ($urandom_range(0, 99) >= 12);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > MAX_CYC) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (state_q.size() == 0) begin
        $display("%0t: unexpected item %h", $time, out_data);
        errors++;
      end else begin
        out_item_t e;
        e = state_q.pop_front();
        for (int j = 0; j < HID_N; j++)
          if (e[127-16*j -: 16] !== out_data[127-16*j -: 16]) begin
            $display("%0t: h_%0d expected %h actual %h", $time, j,
                     e[127-16*j -: 16], out_data[127-16*j -: 16]);
            errors++;
          end
      end
    end
  end

  initial begin
    in_item_t it;
    quiet    = 1'b0;
    hold_req = 1'b0;
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_data  = '0;
    foreach (gw_mem[k]) gw_mem[k] = 0;
    foreach (gb_mem[k]) gb_mem[k] = 0;
    foreach (cw_mem[k]) cw_mem[k] = 0;
    foreach (cb_mem[k]) cb_mem[k] = 0;
    foreach (hid_vec[k]) hid_vec[k] = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // every weight word gets written before the first step
    for (int a = 0; a < ADDR_N; a++) begin
      it = '0;
      it.cmd = CMD_LOAD;
      it.weight_addr = 9'(a);
      send_item(it);
    end

    foreach (dir_tbl[r]) begin
      it.cmd          = dir_tbl[r].cmd;
      it.weight_addr  = dir_tbl[r].addr;
      it.weight_value = dir_tbl[r].val;
      it.in_0         = dir_tbl[r].x0;
      it.in_1         = dir_tbl[r].x1;
      it.in_2         = dir_tbl[r].x2;
      it.in_3         = dir_tbl[r].x3;
      it.seq_start    = dir_tbl[r].start;
      send_item(it);
      if (dir_tbl[r].chk && state_q.size() > 0)
        state_q[$] = {dir_tbl[r].e0, {7{dir_tbl[r].erest}}};
    end

    for (int n = 0; n < N_RAND; n++) begin
      quiet = (n >= 500 && n < 750);
      if (n == 300) hold_req = 1'b1;
      if (n == 800) begin
        in_valid <= 1'b0;
        wait (state_q.size() == 0);
        @(posedge clk);
      end
      send_item(rand_item());
    end
    in_valid <= 1'b0;

    wait (state_q.size() == 0);
    repeat (DRAIN_CYC) @(posedge clk);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
